FILE: src/rpn_pkg.sv
// Package with the request codes, status codes, sizes, item types and state types of the RPN calculator.
package rpn_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int VAR_COUNT_DEF   = 26;
    localparam int DATA_W          = 32;
    localparam int REQ_W           = 4;
    localparam int VIX_W           = 5;
    localparam int STATUS_W        = 3;
    localparam int DEPTH_W         = $clog2(STACK_DEPTH_DEF + 1);

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_PUSH   = 4'd0;
    localparam logic [REQ_W-1:0] REQ_ADD    = 4'd1;
    localparam logic [REQ_W-1:0] REQ_SUB    = 4'd2;
    localparam logic [REQ_W-1:0] REQ_MUL    = 4'd3;
    localparam logic [REQ_W-1:0] REQ_DIV    = 4'd4;
    localparam logic [REQ_W-1:0] REQ_MOD    = 4'd5;
    localparam logic [REQ_W-1:0] REQ_STORE  = 4'd6;
    localparam logic [REQ_W-1:0] REQ_RECALL = 4'd7;
    localparam logic [REQ_W-1:0] REQ_DUP    = 4'd8;
    localparam logic [REQ_W-1:0] REQ_SWAP   = 4'd9;
    localparam logic [REQ_W-1:0] REQ_TOP    = 4'd10;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 4'd11;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FEW  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZ = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SAT  = 3'd4;

    // One token on the request channel.
    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic signed [DATA_W-1:0] number_in;
        logic [VIX_W-1:0]         var_index;
    } req_item_t;

    // One result on the response channel.
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] top_value;
        logic [DEPTH_W-1:0]       stack_depth;
    } rsp_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_DIVFIN,
        S_WB,
        S_CLEAR,
        S_OUT
    } state_t;

    // Request to the divider and its answer.
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
        logic [31:0] rem;
    } div_rsp_t;

endpackage

FILE: src/rpn_if.sv
// Valid/ready channel interface carrying one payload.
interface rpn_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/rpn_div.sv
// Restoring divider on magnitudes: 64-bit dividend by 32-bit divisor, one bit a cycle.
module rpn_div (
    input  logic              clk,
    input  logic              rst_n,
    input  rpn_pkg::div_req_t req,
    output rpn_pkg::div_rsp_t rsp
);
    logic [63:0] quot_reg, quot_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    // One shift and trial subtract per cycle; the remainder stays below the divisor.
    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quot_reg[63]} - {1'b0, dsr_reg};
        if (req.start)
        begin
            quot_next = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                quot_next = {quot_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[30:0], quot_reg[63]};
                quot_next = {quot_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;
endmodule

FILE: src/rpn_stack_calculator_unit.sv
// Top level of the RPN calculator: stack memory, variable memory, sequencer and divider.
//
// Usage: one token enters on the "req" channel (req_type, number_in, var_index)
// and exactly one result leaves on the "rsp" channel (status, top_value,
// stack_depth). Both channels are valid/ready; an item moves on an edge where
// both are high. The block works on one token at a time: stack operands are
// read from a one-port synchronous stack memory, one entry per cycle, the
// result is written back and the new top is read again before the result
// item is shown. Push, top, an ignored token and a token that fails its
// first check go straight to write-back; recall, store, dup and a zero
// divisor read one entry first; swap reads two entries and writes both back;
// add, sub, mul, div and mod read two operands (unary minus reads one) and
// pass through the execute state, mul adds a shift state and div and mod wait
// on the 64-step restoring divider. Clear sweeps the variable memory, one
// entry a cycle. The result sits in an output register; a new token is taken
// only after it has been delivered, and a stalled receiver holds the block.
// Reset empties the stack, marks every variable as zero through
// per-variable valid bits and clears the last recalled index.
// Stack entries are undefined until written and never read before that.
module rpn_stack_calculator_unit #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
    parameter int VAR_COUNT   = rpn_pkg::VAR_COUNT_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    rpn_if.sink   req,
    rpn_if.source rsp
);
    localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int VW  = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
    localparam logic signed [31:0] MAXV = 32'sh7FFFFFFF;
    localparam logic signed [31:0] MINV = 32'sh80000000;

    rpn_pkg::state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic [4:0]    lastrec_reg, lastrec_next;
    logic [3:0]    op_reg, op_next;
    logic signed [31:0] a_reg, a_next, b_reg, b_next;
    logic signed [63:0] wide_reg, wide_next;
    logic [2:0]    st_reg, st_next;
    logic [1:0]    wcnt_reg, wcnt_next;
    logic [VW-1:0] clr_reg, clr_next;
    logic [VAR_COUNT-1:0] vvalid_reg, vvalid_next;

    logic [2:0]  ost_reg, ost_next;
    logic [31:0] otop_reg, otop_next;
    logic [rpn_pkg::DEPTH_W-1:0] odep_reg, odep_next;
    logic        ovalid_reg, ovalid_next;

    // Stack memory: one port, read data registered.
    logic signed [31:0] smem [STACK_DEPTH];
    logic          s_we, s_re;
    logic [AW-1:0] s_addr;
    logic signed [31:0] s_wdata, s_rdata;

    always_ff @(posedge clk)
    begin
        if (s_we)
            smem[s_addr] <= s_wdata;
        if (s_re)
            s_rdata <= smem[s_addr];
    end

    // Variable memory: one port, valid bits give the zero reset value.
    logic signed [31:0] vmem [VAR_COUNT];
    logic          v_we, v_re;
    logic [VW-1:0] v_addr;
    logic signed [31:0] v_wdata, v_rdata;
    logic          v_rvalid;

    always_ff @(posedge clk)
    begin
        if (v_we)
            vmem[v_addr] <= v_wdata;
        if (v_re)
        begin
            v_rdata  <= vmem[v_addr];
            v_rvalid <= vvalid_reg[v_addr];
        end
    end

    // Shared divider.
    rpn_pkg::div_req_t dreq;
    rpn_pkg::div_rsp_t drsp;
    rpn_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic signed [31:0] ia, ib;
    logic signed [63:0] sum, prod;
    logic [63:0] mag_n;
    logic [31:0] mag_d;
    logic signed [63:0] q_s;
    logic signed [31:0] r_s;
    logic signed [31:0] clampv;
    logic          sat;
    logic signed [31:0] varval;

    always_comb
    begin
        // Integer parts truncated toward zero.
        ia = (a_reg < 0) ? -(32'(((-64'(a_reg)) >> 16))) : (a_reg >>> 16);
        ib = (b_reg < 0) ? -(32'(((-64'(b_reg)) >> 16))) : (b_reg >>> 16);
        sum = (op_reg == rpn_pkg::REQ_ADD) ? 64'(a_reg) + 64'(b_reg)
                                           : 64'(a_reg) - 64'(b_reg);
        prod = 64'(a_reg) * 64'(b_reg);
        if (op_reg == rpn_pkg::REQ_DIV)
        begin
            mag_n = (a_reg < 0) ? 64'(-(64'(a_reg) <<< 16)) : 64'(64'(a_reg) <<< 16);
            mag_d = (b_reg < 0) ? 32'(-64'(b_reg)) : b_reg;
        end
        else
        begin
            mag_n = (ia < 0) ? 64'(-64'(ia)) : 64'(ia);
            mag_d = (ib < 0) ? 32'(-64'(ib)) : ib;
        end
        q_s = ((a_reg < 0) != (b_reg < 0)) ? -$signed(drsp.quot) : $signed(drsp.quot);
        r_s = (a_reg < 0) ? -$signed(drsp.rem) : $signed(drsp.rem);
        if (wide_reg > 64'(MAXV))
        begin
            clampv = MAXV;
            sat = 1'b1;
        end
        else if (wide_reg < 64'(MINV))
        begin
            clampv = MINV;
            sat = 1'b1;
        end
        else
        begin
            clampv = wide_reg[31:0];
            sat = 1'b0;
        end
        varval = v_rvalid ? v_rdata : '0;
    end

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        lastrec_next = lastrec_reg;
        op_next      = op_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        wide_next    = wide_reg;
        st_next      = st_reg;
        wcnt_next    = wcnt_reg;
        clr_next     = clr_reg;
        vvalid_next  = vvalid_reg;
        ost_next     = ost_reg;
        otop_next    = otop_reg;
        odep_next    = odep_reg;
        ovalid_next  = ovalid_reg;
        s_we = 1'b0; s_re = 1'b0; s_addr = '0; s_wdata = '0;
        v_we = 1'b0; v_re = 1'b0; v_addr = '0; v_wdata = '0;
        dreq.start = 1'b0; dreq.dividend = mag_n; dreq.divisor = mag_d;
        req.ready = 1'b0;

        if (ovalid_reg && rsp.ready)
            ovalid_next = 1'b0;

        unique case (state_reg)
            rpn_pkg::S_IDLE:
            begin
                req.ready = !ovalid_reg;
                if (req.valid && !ovalid_reg)
                begin
                    op_next  = req.payload.req_type;
                    st_next  = rpn_pkg::ST_OK;
                    wcnt_next = 2'd0;
                    state_next = rpn_pkg::S_WB;
                    unique case (req.payload.req_type) inside
                        rpn_pkg::REQ_PUSH:
                        begin
                            if (count_reg >= CW'(STACK_DEPTH))
                                st_next = rpn_pkg::ST_FULL;
                            else
                            begin
                                s_we = 1'b1;
                                s_addr = AW'(count_reg);
                                s_wdata = req.payload.number_in;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        rpn_pkg::REQ_ADD, rpn_pkg::REQ_MUL, rpn_pkg::REQ_DIV,
                        rpn_pkg::REQ_MOD, rpn_pkg::REQ_SWAP:
                        begin
                            if (count_reg < CW'(2))
                                st_next = rpn_pkg::ST_FEW;
                            else
                            begin
                                s_re = 1'b1;
                                s_addr = AW'(count_reg - 1'b1);
                                state_next = rpn_pkg::S_RD1;
                            end
                        end
                        rpn_pkg::REQ_SUB, rpn_pkg::REQ_STORE, rpn_pkg::REQ_DUP:
                        begin
                            if (count_reg < CW'(1))
                                st_next = rpn_pkg::ST_FEW;
                            else
                            begin
                                s_re = 1'b1;
                                s_addr = AW'(count_reg - 1'b1);
                                state_next = rpn_pkg::S_RD1;
                            end
                        end
                        rpn_pkg::REQ_RECALL:
                        begin
                            if ({1'b0, req.payload.var_index} < 6'(VAR_COUNT))
                            begin
                                v_re = 1'b1;
                                v_addr = VW'(req.payload.var_index);
                                lastrec_next = req.payload.var_index;
                                state_next = rpn_pkg::S_RD1;
                            end
                        end
                        rpn_pkg::REQ_TOP:
                        begin
                            if (count_reg < CW'(1))
                                st_next = rpn_pkg::ST_FEW;
                        end
                        rpn_pkg::REQ_CLEAR:
                        begin
                            count_next = '0;
                            vvalid_next = '0;
                        end
                        default: ;
                    endcase
                end
            end

            rpn_pkg::S_RD1:
            begin
                // Top element (or variable) arrives now.
                b_next = s_rdata;
                state_next = rpn_pkg::S_WB;
                if (op_reg == rpn_pkg::REQ_RECALL)
                begin
                    if (count_reg >= CW'(STACK_DEPTH))
                        st_next = rpn_pkg::ST_FULL;
                    else
                    begin
                        s_we = 1'b1;
                        s_addr = AW'(count_reg);
                        s_wdata = varval;
                        count_next = count_reg + 1'b1;
                    end
                end
                else if (op_reg == rpn_pkg::REQ_STORE)
                begin
                    count_next = count_reg - 1'b1;
                    if ({1'b0, lastrec_reg} < 6'(VAR_COUNT))
                    begin
                        v_we = 1'b1;
                        v_addr = VW'(lastrec_reg);
                        v_wdata = s_rdata;
                        vvalid_next[VW'(lastrec_reg)] = 1'b1;
                    end
                end
                else if (op_reg == rpn_pkg::REQ_DUP)
                begin
                    if (count_reg >= CW'(STACK_DEPTH))
                        st_next = rpn_pkg::ST_FULL;
                    else
                    begin
                        s_we = 1'b1;
                        s_addr = AW'(count_reg);
                        s_wdata = s_rdata;
                        count_next = count_reg + 1'b1;
                    end
                end
                else if (op_reg == rpn_pkg::REQ_SUB && count_reg == CW'(1))
                begin
                    a_next = '0;
                    state_next = rpn_pkg::S_EXEC;
                end
                else if (op_reg == rpn_pkg::REQ_DIV && s_rdata == 0)
                begin
                    st_next = rpn_pkg::ST_DIVZ;
                    count_next = count_reg - 1'b1;
                end
                else if (op_reg == rpn_pkg::REQ_MOD && s_rdata > -32'sd65536
                         && s_rdata < 32'sd65536)
                begin
                    st_next = rpn_pkg::ST_DIVZ;
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    s_re = 1'b1;
                    s_addr = AW'(count_reg - CW'(2));
                    state_next = rpn_pkg::S_RD2;
                end
            end

            rpn_pkg::S_RD2:
            begin
                a_next = s_rdata;
                if (op_reg == rpn_pkg::REQ_SWAP)
                begin
                    s_we = 1'b1;
                    s_addr = AW'(count_reg - CW'(2));
                    s_wdata = b_reg;
                    wcnt_next = 2'd1;
                    state_next = rpn_pkg::S_WB;
                end
                else
                    state_next = rpn_pkg::S_EXEC;
            end

            rpn_pkg::S_EXEC:
            begin
                if (op_reg == rpn_pkg::REQ_MUL)
                begin
                    wide_next = prod;
                    state_next = rpn_pkg::S_MUL;
                end
                else if (op_reg == rpn_pkg::REQ_DIV || op_reg == rpn_pkg::REQ_MOD)
                begin
                    dreq.start = 1'b1;
                    state_next = rpn_pkg::S_DIV;
                end
                else
                begin
                    wide_next = sum;
                    state_next = rpn_pkg::S_DIVFIN;
                end
            end

            rpn_pkg::S_MUL:
            begin
                // Arithmetic shift floors toward minus infinity.
                wide_next = wide_reg >>> 16;
                state_next = rpn_pkg::S_DIVFIN;
            end

            rpn_pkg::S_DIV:
            begin
                if (drsp.done)
                begin
                    if (op_reg == rpn_pkg::REQ_DIV)
                        wide_next = q_s;
                    else
                        wide_next = 64'(r_s) <<< 16;
                    state_next = rpn_pkg::S_DIVFIN;
                end
            end

            rpn_pkg::S_DIVFIN:
            begin
                // Clamp and push the result in place of the operands.
                if (sat)
                    st_next = rpn_pkg::ST_SAT;
                s_we = 1'b1;
                if (op_reg == rpn_pkg::REQ_SUB && count_reg == CW'(1))
                begin
                    s_addr = '0;
                    count_next = count_reg;
                end
                else
                begin
                    s_addr = AW'(count_reg - CW'(2));
                    count_next = count_reg - 1'b1;
                end
                s_wdata = clampv;
                state_next = rpn_pkg::S_WB;
            end

            rpn_pkg::S_WB:
            begin
                if (wcnt_reg == 2'd1)
                begin
                    s_we = 1'b1;
                    s_addr = AW'(count_reg - 1'b1);
                    s_wdata = a_reg;
                    wcnt_next = 2'd0;
                end
                else
                begin
                    if (count_reg != '0)
                    begin
                        s_re = 1'b1;
                        s_addr = AW'(count_reg - 1'b1);
                    end
                    state_next = (op_reg == rpn_pkg::REQ_CLEAR) ? rpn_pkg::S_CLEAR
                                                                 : rpn_pkg::S_OUT;
                    clr_next = '0;
                end
            end

            rpn_pkg::S_CLEAR:
            begin
                // Sweep the variable memory to zero, one entry a cycle.
                v_we = 1'b1;
                v_addr = clr_reg;
                v_wdata = '0;
                vvalid_next[clr_reg] = 1'b1;
                if (clr_reg == VW'(VAR_COUNT - 1))
                    state_next = rpn_pkg::S_OUT;
                else
                    clr_next = clr_reg + 1'b1;
            end

            rpn_pkg::S_OUT:
            begin
                ost_next = st_reg;
                otop_next = (count_reg != '0) ? s_rdata : '0;
                odep_next = rpn_pkg::DEPTH_W'(count_reg);
                ovalid_next = 1'b1;
                state_next = rpn_pkg::S_IDLE;
            end

            default: state_next = rpn_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rpn_pkg::S_IDLE;
            count_reg   <= '0;
            lastrec_reg <= '0;
            vvalid_reg  <= '0;
            ovalid_reg  <= 1'b0;
            wcnt_reg    <= '0;
            clr_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            lastrec_reg <= lastrec_next;
            vvalid_reg  <= vvalid_next;
            ovalid_reg  <= ovalid_next;
            wcnt_reg    <= wcnt_next;
            clr_reg     <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        wide_reg <= wide_next;
        st_reg   <= st_next;
        ost_reg  <= ost_next;
        otop_reg <= otop_next;
        odep_reg <= odep_next;
    end

    assign rsp.valid               = ovalid_reg;
    assign rsp.payload.status      = ost_reg;
    assign rsp.payload.top_value   = otop_reg;
    assign rsp.payload.stack_depth = odep_reg;

    // The stack never holds more than its depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // No token is taken while a result waits.
    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> !req.ready)
        else $error("token accepted while result pending");

    // A result is raised only from the output state.
    a_out_from_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg) == rpn_pkg::S_OUT)
        else $error("result raised outside output state");

    // A waiting result holds its top value and depth.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && !rsp.ready |=> $stable(otop_reg) && $stable(odep_reg))
        else $error("result changed while stalled");
endmodule

FILE: test/tb_rpn_stack_calculator_unit.sv
// Testbench for the RPN calculator: directed and random tokens, checked against a Q16.16 predictor.
`timescale 1ns / 1ps

module tb_rpn_stack_calculator_unit;

    localparam int STACK_MAX    = rpn_pkg::STACK_DEPTH_DEF;
    localparam int VARS         = rpn_pkg::VAR_COUNT_DEF;
    localparam int ONE_Q        = 65536;
    localparam int STALL_LIMIT  = 5000;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE_TIME  = 120;
    localparam int RANDOM_ITEMS = 500;

    typedef logic [rpn_pkg::REQ_W-1:0]  req_code_t;
    typedef logic [rpn_pkg::DATA_W-1:0] data_t;
    typedef logic [rpn_pkg::VIX_W-1:0]  vix_t;
    typedef logic [rpn_pkg::DEPTH_W-1:0] depth_t;

    // Highest request code; codes above clear are not assigned.
    localparam req_code_t REQ_SPARE = '1;

    logic clk;
    logic rst_n;

    rpn_if #(.payload_t(rpn_pkg::req_item_t)) req ();
    rpn_if #(.payload_t(rpn_pkg::rsp_item_t)) rsp ();

    rpn_stack_calculator_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // Predictor state: a shadow of the value stack and the variables.
    int          calc_stack [STACK_MAX];
    int          calc_depth;
    int          calc_vars [VARS];
    int unsigned calc_last;

    rpn_pkg::rsp_item_t pending_results [$];
    int          mismatch_count;
    int          tokens_taken;
    int          results_seen;
    int          status_hits [5];
    bit          idle_enable;
    int          hold_asks;
    int          holds_begun;
    int          hold_left;
    int          quiet_cycles;
    bit          failed;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Work out the result of one token and advance the shadow state.
    function automatic rpn_pkg::rsp_item_t predict_token(rpn_pkg::req_item_t t);
        rpn_pkg::rsp_item_t r;
        logic [2:0]  st;
        longint      a;
        longint      b;
        longint      v;
        bit          push_v;
        st = rpn_pkg::ST_OK;
        push_v = 1'b0;
        v = 0;
        case (t.req_type) inside
            rpn_pkg::REQ_PUSH:
            begin
                if (calc_depth >= STACK_MAX)
                    st = rpn_pkg::ST_FULL;
                else
                begin
                    calc_stack[calc_depth] = t.number_in;
                    calc_depth++;
                end
            end
            rpn_pkg::REQ_ADD, rpn_pkg::REQ_MUL, rpn_pkg::REQ_DIV, rpn_pkg::REQ_MOD:
            begin
                if (calc_depth < 2)
                    st = rpn_pkg::ST_FEW;
                else
                begin
                    b = calc_stack[calc_depth-1];
                    calc_depth--;
                    if ((t.req_type == rpn_pkg::REQ_DIV && b == 0) ||
                        (t.req_type == rpn_pkg::REQ_MOD && b / ONE_Q == 0))
                        st = rpn_pkg::ST_DIVZ;
                    else
                    begin
                        a = calc_stack[calc_depth-1];
                        calc_depth--;
                        case (t.req_type)
                            rpn_pkg::REQ_ADD: v = a + b;
                            rpn_pkg::REQ_MUL: v = (a * b) >>> 16;
                            rpn_pkg::REQ_DIV: v = (a * ONE_Q) / b;
                            default: v = ((a / ONE_Q) % (b / ONE_Q)) * ONE_Q;
                        endcase
                        push_v = 1'b1;
                    end
                end
            end
            rpn_pkg::REQ_SUB:
            begin
                if (calc_depth < 1)
                    st = rpn_pkg::ST_FEW;
                else
                begin
                    b = calc_stack[calc_depth-1];
                    calc_depth--;
                    if (calc_depth == 0)
                        v = -b;
                    else
                    begin
                        a = calc_stack[calc_depth-1];
                        calc_depth--;
                        v = a - b;
                    end
                    push_v = 1'b1;
                end
            end
            rpn_pkg::REQ_STORE:
            begin
                if (calc_depth < 1)
                    st = rpn_pkg::ST_FEW;
                else
                begin
                    calc_depth--;
                    if (calc_last < VARS)
                        calc_vars[calc_last] = calc_stack[calc_depth];
                end
            end
            rpn_pkg::REQ_RECALL:
            begin
                if (t.var_index < VARS)
                begin
                    if (calc_depth >= STACK_MAX)
                        st = rpn_pkg::ST_FULL;
                    else
                    begin
                        calc_stack[calc_depth] = calc_vars[t.var_index];
                        calc_depth++;
                    end
                    calc_last = t.var_index;
                end
            end
            rpn_pkg::REQ_DUP:
            begin
                if (calc_depth < 1)
                    st = rpn_pkg::ST_FEW;
                else if (calc_depth >= STACK_MAX)
                    st = rpn_pkg::ST_FULL;
                else
                begin
                    calc_stack[calc_depth] = calc_stack[calc_depth-1];
                    calc_depth++;
                end
            end
            rpn_pkg::REQ_SWAP:
            begin
                if (calc_depth < 2)
                    st = rpn_pkg::ST_FEW;
                else
                begin
                    a = calc_stack[calc_depth-1];
                    calc_stack[calc_depth-1] = calc_stack[calc_depth-2];
                    calc_stack[calc_depth-2] = int'(a);
                end
            end
            rpn_pkg::REQ_TOP:
            begin
                if (calc_depth < 1)
                    st = rpn_pkg::ST_FEW;
            end
            rpn_pkg::REQ_CLEAR:
            begin
                calc_depth = 0;
                foreach (calc_vars[i])
                    calc_vars[i] = 0;
            end
            default:
            begin
            end
        endcase
        // Arithmetic results are clamped to the 32-bit range.
        if (push_v)
        begin
            if (v > 64'sd2147483647)
            begin
                v = 64'sd2147483647;
                st = rpn_pkg::ST_SAT;
            end
            else if (v < -64'sd2147483648)
            begin
                v = -64'sd2147483648;
                st = rpn_pkg::ST_SAT;
            end
            calc_stack[calc_depth] = int'(v);
            calc_depth++;
        end
        r.status = st;
        r.top_value = (calc_depth > 0) ? calc_stack[calc_depth-1] : 0;
        r.stack_depth = depth_t'(calc_depth);
        return r;
    endfunction

    // Predict each accepted token.
    always @(posedge clk)
    begin
        if (rst_n && req.valid && req.ready)
        begin
            pending_results.push_back(predict_token(req.payload));
            tokens_taken++;
        end
    end

    // Compare each delivered result with the oldest prediction.
    always @(posedge clk)
    begin
        rpn_pkg::rsp_item_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected result status=%0d top=%h depth=%0d",
                             rsp.payload.status, rsp.payload.top_value,
                             rsp.payload.stack_depth);
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp.payload.status < 5)
                    status_hits[rsp.payload.status]++;
                if (rsp.payload.status !== want.status ||
                    rsp.payload.top_value !== want.top_value ||
                    rsp.payload.stack_depth !== want.stack_depth)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: status %0d/%0d top %h/%h depth %0d/%0d (exp/act)",
                                 want.status, rsp.payload.status, want.top_value,
                                 rsp.payload.top_value, want.stack_depth,
                                 rsp.payload.stack_depth);
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off each time one is asked for.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            hold_left <= 0;
            holds_begun <= 0;
        end
        else if (hold_asks != holds_begun && hold_left == 0)
        begin
            hold_left <= LONG_HOLD;
            holds_begun <= holds_begun + 1;
            rsp.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= !(idle_enable && $urandom_range(99) < 34);
    end

    // Watchdog on cycles with no accepted item on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog expired with %0d results outstanding",
                     pending_results.size());
            $display("tb_rpn_stack_calculator_unit failed");
            $finish;
        end
    end

    // Offer one token, with random gaps first, and wait until it is taken.
    task automatic send_token(req_code_t kind, data_t num, vix_t vix);
        @(negedge clk);
        while (idle_enable && $urandom_range(99) < 34)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.payload <= '{req_type: kind, number_in: num, var_index: vix};
        do
            @(posedge clk);
        while (!(req.valid && req.ready));
    endtask

    task automatic lower_valid();
        @(negedge clk);
        req.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        lower_valid();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Extremes, each operation and each special case.
    task automatic test_directed();
        send_token(rpn_pkg::REQ_TOP, 0, 0);                    // top on empty stack
        send_token(rpn_pkg::REQ_SUB, 0, 0);                    // sub on empty stack
        send_token(rpn_pkg::REQ_PUSH, 32'h8000_0000, 0);
        send_token(rpn_pkg::REQ_SUB, 0, 0);                    // negating the minimum saturates
        send_token(rpn_pkg::REQ_PUSH, 32'h0001_0000, 0);
        send_token(rpn_pkg::REQ_ADD, 0, 0);                    // max plus one saturates
        send_token(rpn_pkg::REQ_PUSH, 32'h0003_8000, 0);
        send_token(rpn_pkg::REQ_MUL, 0, 0);
        send_token(rpn_pkg::REQ_PUSH, 32'h0000_0000, 0);
        send_token(rpn_pkg::REQ_DIV, 0, 0);                    // zero divisor
        send_token(rpn_pkg::REQ_PUSH, 32'hFFFD_0000, 0);
        send_token(rpn_pkg::REQ_DIV, 0, 0);
        send_token(rpn_pkg::REQ_PUSH, 32'h0000_8000, 0);
        send_token(rpn_pkg::REQ_MOD, 0, 0);                    // divisor integer part is zero
        send_token(rpn_pkg::REQ_PUSH, 32'hFFF9_0000, 0);
        send_token(rpn_pkg::REQ_SWAP, 0, 0);
        send_token(rpn_pkg::REQ_MOD, 0, 0);
        send_token(rpn_pkg::REQ_RECALL, 0, 25);
        send_token(rpn_pkg::REQ_STORE, 0, 0);                  // into the last variable
        send_token(rpn_pkg::REQ_RECALL, 0, 31);                // out-of-range variable
        send_token(rpn_pkg::REQ_DUP, 0, 0);
        send_token(rpn_pkg::REQ_RECALL, 0, 25);
        send_token(REQ_SPARE, 32'hFFFF_FFFF, 5'h1F);           // unknown request
        send_token(rpn_pkg::REQ_CLEAR, 0, 0);
        send_token(rpn_pkg::REQ_RECALL, 0, 25);
    endtask

    // Fill the stack to the top, then push, dup and recall on a full stack.
    task automatic test_full_stack();
        send_token(rpn_pkg::REQ_CLEAR, 0, 0);
        for (int i = 0; i < STACK_MAX; i++)
            send_token(rpn_pkg::REQ_PUSH, $urandom, 0);
        send_token(rpn_pkg::REQ_PUSH, 32'h1234_5678, 0);
        send_token(rpn_pkg::REQ_DUP, 0, 0);
        send_token(rpn_pkg::REQ_RECALL, 0, 3);
        send_token(rpn_pkg::REQ_STORE, 0, 0);
        send_token(rpn_pkg::REQ_RECALL, 0, 3);
        send_token(rpn_pkg::REQ_CLEAR, 0, 0);
    endtask

    // Hold the receiver off while the sender keeps offering tokens.
    task automatic test_receiver_hold();
        hold_asks++;
        for (int i = 0; i < 8; i++)
            send_token(rpn_pkg::REQ_PUSH, $urandom_range(200) << 16, 0);
        send_token(rpn_pkg::REQ_CLEAR, 0, 0);
        wait_drained();
    endtask

    // Mostly well-formed expressions with random operands, some noise.
    task automatic test_random(int count);
        int  pick;
        data_t num;
        for (int i = 0; i < count; i++)
        begin
            idle_enable = !(i >= count / 3 && i < count / 2);
            pick = $urandom_range(99);
            if ($urandom_range(3) == 0)
                num = $urandom;
            else
                num = ($urandom_range(400) - 200) * ONE_Q + $urandom_range(65535);
            if (i == count / 2)
                wait_drained();
            if (calc_depth < 2 && pick < 75)
                send_token(rpn_pkg::REQ_PUSH, num, vix_t'($urandom));
            else if (pick < 30)
                send_token(rpn_pkg::REQ_PUSH, num, vix_t'($urandom));
            else if (pick < 80)
                send_token(req_code_t'($urandom_range(rpn_pkg::REQ_MOD, rpn_pkg::REQ_ADD)),
                           num, vix_t'($urandom));
            else if (pick < 94)
                send_token(req_code_t'($urandom_range(rpn_pkg::REQ_TOP, rpn_pkg::REQ_STORE)),
                           num, ($urandom_range(99) < 85) ? vix_t'($urandom_range(VARS - 1))
                                                          : vix_t'($urandom));
            else if (pick < 97)
                send_token(req_code_t'($urandom_range(REQ_SPARE, rpn_pkg::REQ_CLEAR)),
                           num, vix_t'($urandom));
            else
                send_token(req_code_t'($urandom_range(REQ_SPARE)), num, vix_t'($urandom));
        end
    endtask

    // Test sequence.
    initial
    begin
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.payload = '0;
        idle_enable = 1'b1;
        hold_asks = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_full_stack();
        test_receiver_hold();
        test_random(RANDOM_ITEMS);
        wait_drained();
        repeat (SETTLE_TIME) @(posedge clk);

        failed = (mismatch_count != 0) || (pending_results.size() != 0);
        $display("Covered %0d tokens and %0d results: ok %0d, too few %0d, full %0d,",
                 tokens_taken, results_seen, status_hits[0], status_hits[1],
                 status_hits[2]);
        $display("divide by zero %0d, saturated %0d; %0d mismatches.",
                 status_hits[3], status_hits[4], mismatch_count);
        if (!failed)
            $display("tb_rpn_stack_calculator_unit passed");
        else
            $display("tb_rpn_stack_calculator_unit failed");
        $finish;
    end

endmodule
